@@ src/panel_level_lock_solo_control_defines.svh @@
// Assertion macros for the checker file of the panel control block.
`ifndef PANEL_LEVEL_LOCK_SOLO_CONTROL_DEFINES_SVH
`define PANEL_LEVEL_LOCK_SOLO_CONTROL_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLLSC_ASSERT_SAME(lbl, ck, rstn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |-> (post)) \
		else $error("pllsc: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PLLSC_ASSERT_NEXT(lbl, ck, rstn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |=> (post)) \
		else $error("pllsc: next-cycle check failed");

`endif

@@ src/pllsc_pkg.sv @@
// Package with widths, codes and types of the panel control block.
`timescale 1ns / 1ps

package pllsc_pkg;

	localparam int NUM_CHANNELS_DEF = 4;

	localparam int KIND_W     = 3;
	localparam int CH_W       = 2;
	localparam int STEPS_W    = 8;
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 7;
	localparam int MASK_W     = 4;
	localparam int MS_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_DEFAULT = 7'd50;

	// Register values after reset.
	localparam logic [MS_W-1:0]    FINE_INTERVAL_RST = 16'd100;
	localparam logic [LEVEL_W-1:0] FINE_STEP_RST     = 7'd1;
	localparam logic [LEVEL_W-1:0] COARSE_STEP_RST   = 7'd2;
	localparam logic [MS_W-1:0]    RETRIG_RST        = 16'd80;
	localparam logic [MS_W-1:0]    FLASH_PULSE_RST   = 16'd600;

	// Item kinds; the two remaining codes change nothing.
	typedef enum logic [KIND_W-1:0] {
		KIND_ENCODER     = 3'd0,
		KIND_SHORT_PRESS = 3'd1,
		KIND_LONG_PRESS  = 3'd2,
		KIND_REC_TRIGGER = 3'd3,
		KIND_FRAME_BEGIN = 3'd4,
		KIND_RESET_ALL   = 3'd5
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FINE_INTERVAL = 3'd0,
		REG_FINE_STEP     = 3'd1,
		REG_COARSE_STEP   = 3'd2,
		REG_RETRIG        = 3'd3,
		REG_FLASH_PULSE   = 3'd4
	} cfg_reg_t;

	// One result word as held in the output register.
	typedef struct packed {
		logic [LEVEL_W-1:0] channel_level;
		logic [MASK_W-1:0]  locked_mask;
		logic [MASK_W-1:0]  solo_mask;
		logic               activity;
		logic               level_edit_activity;
		logic               flash_active;
		logic               trigger_request;
	} result_t;

endpackage

@@ src/pllsc_cmd_if.sv @@
// Input channel of the panel control block: valid, ready and one item word.
`timescale 1ns / 1ps

interface pllsc_cmd_if
	import pllsc_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [CH_W-1:0]           channel;
	logic signed [STEPS_W-1:0] steps;
	logic [TIME_W-1:0]         now_ms;

	modport source (output valid, kind, channel, steps, now_ms, input ready);
	modport sink (input valid, kind, channel, steps, now_ms, output ready);
endinterface

@@ src/pllsc_rsp_if.sv @@
// Output channel of the panel control block: valid, ready and one result word.
`timescale 1ns / 1ps

interface pllsc_rsp_if
	import pllsc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] channel_level;
	logic [MASK_W-1:0]  locked_mask;
	logic [MASK_W-1:0]  solo_mask;
	logic               activity;
	logic               level_edit_activity;
	logic               flash_active;
	logic               trigger_request;

	modport source (output valid, channel_level, locked_mask, solo_mask, activity,
		level_edit_activity, flash_active, trigger_request, input ready);
	modport sink (input valid, channel_level, locked_mask, solo_mask, activity,
		level_edit_activity, flash_active, trigger_request, output ready);
endinterface

@@ src/panel_level_lock_solo_control.sv @@
// Top level of the panel control block: levels, lock, solo, record trigger.
//
//   Port   Direction  Handshake      Contents
//   cmd    in         valid/ready    kind, channel, steps, now_ms
//   rsp    out        valid/ready    level, lock and solo masks, flags
//   cfg    in         write enable   register index and 16-bit data
//
// One word per cycle unless rsp stalls; items pass working stage, then output register.
// Level and last turn time per channel sit in one memory with a registered read;
// a write from the item ahead is forwarded to the item right behind it.
// Reset needs no clearing pass: per-channel valid bits stand for the defaults.
// When rsp stalls, one more word is taken into the working stage, then cmd waits.
`timescale 1ns / 1ps

module panel_level_lock_solo_control
	import pllsc_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pllsc_cmd_if.sink             cmd,
	pllsc_rsp_if.source           rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int MEM_W = TIME_W + LEVEL_W;
	localparam int PROD_W = 2 * STEPS_W;
	localparam int SUM_W = PROD_W + 1;

	// Configuration registers.
	logic [MS_W-1:0]    fine_interval_q;
	logic [LEVEL_W-1:0] fine_step_q;
	logic [LEVEL_W-1:0] coarse_step_q;
	logic [MS_W-1:0]    retrig_q;
	logic [MS_W-1:0]    flash_pulse_q;

	// Shared state outside the memory.
	logic [MASK_W-1:0]       lock_q, lock_nx;
	logic [MASK_W-1:0]       solo_q, solo_nx;
	logic                    act_any_q, act_any_nx;
	logic                    act_edit_q, act_edit_nx;
	logic [TIME_W-1:0]       last_trig_q, last_trig_nx;
	logic [TIME_W-1:0]       flash_end_q, flash_end_nx;
	logic [NUM_CHANNELS-1:0] lvl_vld_q, lvl_vld_nx;
	logic [NUM_CHANNELS-1:0] time_vld_q, time_vld_nx;

	// Per-channel memory: {last turn time, level}.
	logic [MEM_W-1:0] chan_mem [NUM_CHANNELS];

	// Working stage.
	logic                      s1_vld_q;
	logic [KIND_W-1:0]         kind_s1;
	logic [CH_W-1:0]           ch_s1;
	logic signed [STEPS_W-1:0] steps_s1;
	logic [TIME_W-1:0]         now_s1;
	logic [MEM_W-1:0]          rd_word_s1;
	logic                      fwd_hit_s1;
	logic [MEM_W-1:0]          fwd_word_s1;

	// Output register.
	logic    rsp_vld_q;
	result_t rsp_q;
	result_t res;

	logic               cmd_acc;
	logic               s1_fire;
	logic [CH_AW-1:0]   cmd_addr;
	logic [CH_AW-1:0]   addr_s1;
	logic               ch_ok;
	logic [MEM_W-1:0]   cur_word;
	logic [LEVEL_W-1:0] cur_level;
	logic [TIME_W-1:0]  cur_time;
	logic [TIME_W-1:0]  turn_elapsed;
	logic [LEVEL_W-1:0] step_sz;
	logic signed [PROD_W-1:0] steps_x;
	logic signed [PROD_W-1:0] step_x;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0]  lv_sum;
	logic [LEVEL_W-1:0] lv_new;
	logic               enc_write;
	logic               big_turn;
	logic [TIME_W-1:0]  trig_elapsed;
	logic               trig_ok;
	logic               flash_carry;
	logic [TIME_W-1:0]  flash_sum;
	logic [MASK_W-1:0]  ch_bit;
	logic               mem_we;
	logic [MEM_W-1:0]   wr_word;

	// Handshake: the working stage moves on when the output register is free.
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign s1_fire   = s1_vld_q && (!rsp_vld_q || rsp.ready);
	assign cmd.ready = !s1_vld_q || s1_fire;
	assign cmd_addr  = CH_AW'(cmd.channel);

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_interval_q <= FINE_INTERVAL_RST;
			fine_step_q     <= FINE_STEP_RST;
			coarse_step_q   <= COARSE_STEP_RST;
			retrig_q        <= RETRIG_RST;
			flash_pulse_q   <= FLASH_PULSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FINE_INTERVAL: fine_interval_q <= cfg_wdata;
				REG_FINE_STEP:     fine_step_q     <= cfg_wdata[LEVEL_W-1:0];
				REG_COARSE_STEP:   coarse_step_q   <= cfg_wdata[LEVEL_W-1:0];
				REG_RETRIG:        retrig_q        <= cfg_wdata;
				REG_FLASH_PULSE:   flash_pulse_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Memory: one write port from the working stage, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			chan_mem[addr_s1] <= wr_word;
		end
		if (cmd_acc) begin
			rd_word_s1 <= chan_mem[cmd_addr];
		end
	end

	// Working stage payload, with the forwarding match against this cycle's write.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			kind_s1     <= cmd.kind;
			ch_s1       <= cmd.channel;
			steps_s1    <= cmd.steps;
			now_s1      <= cmd.now_ms;
			fwd_hit_s1  <= mem_we && (addr_s1 == cmd_addr);
			fwd_word_s1 <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (cmd_acc) begin
			s1_vld_q <= 1'b1;
		end else if (s1_fire) begin
			s1_vld_q <= 1'b0;
		end
	end

	// Current entry of the addressed channel; invalid entries read as defaults.
	always_comb begin
		ch_ok     = {{(5 - CH_W){1'b0}}, ch_s1} < 5'(NUM_CHANNELS);
		addr_s1   = CH_AW'(ch_s1);
		cur_word  = fwd_hit_s1 ? fwd_word_s1 : rd_word_s1;
		cur_level = lvl_vld_q[addr_s1] ? cur_word[LEVEL_W-1:0] : LEVEL_DEFAULT;
		cur_time  = time_vld_q[addr_s1] ? cur_word[MEM_W-1:LEVEL_W] : '0;
	end

	// Encoder update: step size by turn spacing, then add and saturate.
	always_comb begin
		turn_elapsed = now_s1 - cur_time;
		step_sz      = (turn_elapsed >= {{(TIME_W - MS_W){1'b0}}, fine_interval_q}) ?
			fine_step_q : coarse_step_q;
		steps_x      = {{(PROD_W - STEPS_W){steps_s1[STEPS_W-1]}}, steps_s1};
		step_x       = {{(PROD_W - LEVEL_W){1'b0}}, step_sz};
		prod         = steps_x * step_x;
		lv_sum       = {prod[PROD_W-1], prod} + {{(SUM_W - LEVEL_W){1'b0}}, cur_level};
		if (lv_sum < 0) begin
			lv_new = '0;
		end else if (lv_sum > {{(SUM_W - LEVEL_W){1'b0}}, LEVEL_MAX}) begin
			lv_new = LEVEL_MAX;
		end else begin
			lv_new = lv_sum[LEVEL_W-1:0];
		end
		enc_write = (kind_s1 == KIND_ENCODER) && ch_ok && (steps_s1 != '0);
		big_turn  = (steps_s1 > 8'sd1) || (steps_s1 < -8'sd1);
		mem_we    = s1_fire && enc_write;
		wr_word   = {now_s1, lv_new};
	end

	// Record trigger: lockout test and flash end time with its carry.
	always_comb begin
		trig_elapsed = now_s1 - last_trig_q;
		trig_ok      = (kind_s1 == KIND_REC_TRIGGER) &&
			(trig_elapsed >= {{(TIME_W - MS_W){1'b0}}, retrig_q});
		{flash_carry, flash_sum} = {1'b0, now_s1} + {{(TIME_W - MS_W + 1){1'b0}}, flash_pulse_q};
	end

	// Next values of the shared state.
	always_comb begin
		lock_nx      = lock_q;
		solo_nx      = solo_q;
		act_any_nx   = act_any_q;
		act_edit_nx  = act_edit_q;
		last_trig_nx = last_trig_q;
		flash_end_nx = flash_end_q;
		lvl_vld_nx   = lvl_vld_q;
		time_vld_nx  = time_vld_q;
		ch_bit       = MASK_W'(1) << ch_s1;
		case (kind_s1)
			KIND_ENCODER: begin
				if (enc_write) begin
					lvl_vld_nx[addr_s1]  = 1'b1;
					time_vld_nx[addr_s1] = 1'b1;
					act_any_nx           = 1'b1;
					if (big_turn) begin
						act_edit_nx = 1'b1;
					end
				end
			end
			KIND_SHORT_PRESS: begin
				if (ch_ok) begin
					lock_nx     = lock_q ^ ch_bit;
					act_any_nx  = 1'b1;
					act_edit_nx = 1'b1;
				end
			end
			KIND_LONG_PRESS: begin
				if (ch_ok) begin
					// Setting solo on one channel clears it everywhere else.
					solo_nx     = ((solo_q & ch_bit) != '0) ? (solo_q & ~ch_bit) : ch_bit;
					act_any_nx  = 1'b1;
					act_edit_nx = 1'b1;
				end
			end
			KIND_REC_TRIGGER: begin
				if (trig_ok) begin
					last_trig_nx = now_s1;
					flash_end_nx = flash_sum;
					act_any_nx   = 1'b1;
				end
			end
			KIND_FRAME_BEGIN: begin
				act_any_nx  = 1'b0;
				act_edit_nx = 1'b0;
			end
			KIND_RESET_ALL: begin
				lvl_vld_nx  = '0;
				lock_nx     = '0;
				solo_nx     = '0;
				act_any_nx  = 1'b1;
				act_edit_nx = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q      <= '0;
			solo_q      <= '0;
			act_any_q   <= 1'b0;
			act_edit_q  <= 1'b0;
			last_trig_q <= '0;
			flash_end_q <= '0;
			lvl_vld_q   <= '0;
			time_vld_q  <= '0;
		end else if (s1_fire) begin
			lock_q      <= lock_nx;
			solo_q      <= solo_nx;
			act_any_q   <= act_any_nx;
			act_edit_q  <= act_edit_nx;
			last_trig_q <= last_trig_nx;
			flash_end_q <= flash_end_nx;
			lvl_vld_q   <= lvl_vld_nx;
			time_vld_q  <= time_vld_nx;
		end
	end

	// Result word after this item's update.
	always_comb begin
		if (!ch_ok) begin
			res.channel_level = '0;
		end else if (kind_s1 == KIND_RESET_ALL) begin
			res.channel_level = LEVEL_DEFAULT;
		end else if (enc_write) begin
			res.channel_level = lv_new;
		end else begin
			res.channel_level = cur_level;
		end
		res.locked_mask         = lock_nx;
		res.solo_mask           = solo_nx;
		res.activity            = act_any_nx;
		res.level_edit_activity = act_edit_nx;
		// A fresh flash is active unless the end time wrapped or the pulse is empty.
		res.flash_active        = trig_ok ? (!flash_carry && (flash_pulse_q != '0)) :
			(now_s1 < flash_end_q);
		res.trigger_request     = trig_ok;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid               = rsp_vld_q;
	assign rsp.channel_level       = rsp_q.channel_level;
	assign rsp.locked_mask         = rsp_q.locked_mask;
	assign rsp.solo_mask           = rsp_q.solo_mask;
	assign rsp.activity            = rsp_q.activity;
	assign rsp.level_edit_activity = rsp_q.level_edit_activity;
	assign rsp.flash_active        = rsp_q.flash_active;
	assign rsp.trigger_request     = rsp_q.trigger_request;

endmodule

@@ src/pllsc_checker.sv @@
// Port-level checker of the panel control block and its bind statement.
`timescale 1ns / 1ps
`include "panel_level_lock_solo_control_defines.svh"

module pllsc_port_checker
	import pllsc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [LEVEL_W-1:0] rsp_channel_level,
	input logic [MASK_W-1:0]  rsp_locked_mask,
	input logic [MASK_W-1:0]  rsp_solo_mask,
	input logic               rsp_activity,
	input logic               rsp_level_edit_activity,
	input logic               rsp_flash_active,
	input logic               rsp_trigger_request
);

	logic [LEVEL_W+2*MASK_W+3:0] rsp_word;

	// Whole result word, for the stall check.
	assign rsp_word = {rsp_channel_level, rsp_locked_mask, rsp_solo_mask, rsp_activity,
		rsp_level_edit_activity, rsp_flash_active, rsp_trigger_request};

	// At most one channel may be soloed.
	`PLLSC_ASSERT_SAME(a_solo_single, clk, arst_n, rsp_valid, $onehot0(rsp_solo_mask))

	// Levels stay within the saturation range.
	`PLLSC_ASSERT_SAME(a_level_range, clk, arst_n, rsp_valid, rsp_channel_level <= LEVEL_MAX)

	// Every edit also counts as activity.
	`PLLSC_ASSERT_SAME(a_edit_is_act, clk, arst_n, rsp_valid && rsp_level_edit_activity, rsp_activity)

	// A stalled result word stays and holds.
	`PLLSC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind panel_level_lock_solo_control pllsc_port_checker u_pllsc_port_checker (
	.clk                     (clk),
	.arst_n                  (arst_n),
	.rsp_valid               (rsp.valid),
	.rsp_ready               (rsp.ready),
	.rsp_channel_level       (rsp.channel_level),
	.rsp_locked_mask         (rsp.locked_mask),
	.rsp_solo_mask           (rsp.solo_mask),
	.rsp_activity            (rsp.activity),
	.rsp_level_edit_activity (rsp.level_edit_activity),
	.rsp_flash_active        (rsp.flash_active),
	.rsp_trigger_request     (rsp.trigger_request)
);
